// ===== design/multichannel_phase_dimmer_defines.svh =====
// assertion macros for the multichannel phase dimmer
// expects aclk and aresetn in the scope where a macro is used
`ifndef MULTICHANNEL_PHASE_DIMMER_DEFINES_SVH
`define MULTICHANNEL_PHASE_DIMMER_DEFINES_SVH

// checked on every clock edge once reset is released
`define MPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every clock edge, reset included
`define MPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/mpd_pkg.sv =====
// shared types and constants for the multichannel phase dimmer
// no dependencies
package mpd_pkg;

    // channel count and derived index width
    localparam int CHANNELS  = 16;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field widths
    localparam int MODE_W    = 2;
    localparam int CHAN_W    = 4;
    localparam int LEVEL_IN_W = 8;
    localparam int LEVEL_W   = 7;
    localparam int COUNT_W   = 8;
    localparam int TICK_W    = 12;
    localparam int GATE_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // level clamp
    localparam logic [LEVEL_IN_W-1:0] LEVEL_MAX_IN = 8'd100;
    localparam logic [LEVEL_W-1:0]    LEVEL_MAX    = 7'd100;

    // register reset values
    localparam logic [COUNT_W-1:0] START_COUNT_RST  = 8'd100;
    localparam logic [COUNT_W-1:0] CUTOFF_COUNT_RST = 8'd5;
    localparam logic [TICK_W-1:0]  SYNC_TIMEOUT_RST = 12'd2000;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_START_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_TIMEOUT = 2'd2;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_TICK        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZERO_CROSS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEVEL_WRITE = 2'd2;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // decoded operation kinds
    typedef enum logic [1:0] {
        OP_TICK,
        OP_ZERO_CROSS,
        OP_LEVEL,
        OP_NOP
    } op_kind_t;

    // one classified word as held in the queue
    typedef struct packed {
        op_kind_t             kind;
        logic                 store;
        logic [CHAN_W-1:0]    chan;
        logic [LEVEL_W-1:0]   level;
        logic                 last;
    } op_t;

    // configuration write
    typedef struct packed {
        logic                  en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // queue status towards the front
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

// ===== design/mpd_front.sv =====
// front end: accepts input words and classifies them into queue operations
// depends on mpd_pkg
module mpd_front import mpd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] channel, [11:4] level, rest zero
    input  logic [MODE_W-1:0]     s_tuser,   // [1:0] mode
    input  logic                  s_tlast,   // frame_last
    input  q_status_t             q_status,
    output logic                  push,
    output op_t                   push_op
);

    logic [CHAN_W-1:0]     chan_in;
    logic [LEVEL_IN_W-1:0] level_in;
    logic                  rst_hold_reg;

    // hold off acceptance in the first cycle after reset is released
    always_ff @(posedge aclk) begin
        rst_hold_reg <= !aresetn;
    end

    assign chan_in  = s_tdata[CHAN_W-1:0];
    assign level_in = s_tdata[CHAN_W +: LEVEL_IN_W];

    assign s_tready = !q_status.full && aresetn && !rst_hold_reg;
    assign push     = s_tvalid && s_tready;

    // decode mode, clamp level, check channel range
    always_comb begin
        push_op = '0;
        case (s_tuser)
            MODE_TICK:        push_op.kind = OP_TICK;
            MODE_ZERO_CROSS:  push_op.kind = OP_ZERO_CROSS;
            MODE_LEVEL_WRITE: push_op.kind = OP_LEVEL;
            default:          push_op.kind = OP_NOP;
        endcase
        push_op.chan  = chan_in;
        push_op.store = ({1'b0, chan_in} < (CHAN_W+1)'(CHANNELS));
        push_op.level = (level_in > LEVEL_MAX_IN) ? LEVEL_MAX : level_in[LEVEL_W-1:0];
        push_op.last  = s_tlast;
    end

endmodule

// ===== design/mpd_queue.sv =====
// short queue of classified operations between front and back
// depends on mpd_pkg
module mpd_queue import mpd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  op_t       push_op,
    input  logic      pop,
    output op_t       head_op,
    output q_status_t status
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    // pointer wrap at the queue depth
    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    assign head_op      = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.count = count_reg;

endmodule

// ===== design/mpd_back.sv =====
// back end: executes queued operations, holds dimmer state and the result register
// depends on mpd_pkg
module mpd_back import mpd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_wr_t              cfg_wr,
    input  op_t                  op,
    input  logic                 op_valid,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [15:0] gate_bits, [16] sync_led, [17] sync_lost
);

    // configuration registers
    logic [COUNT_W-1:0] start_count_reg;
    logic [COUNT_W-1:0] cutoff_count_reg;
    logic [TICK_W-1:0]  sync_timeout_reg;

    // dimmer state
    logic [LEVEL_W-1:0]  active_reg [CHANNELS];
    logic [LEVEL_W-1:0]  active_next [CHANNELS];
    logic [LEVEL_W-1:0]  shadow_reg [CHANNELS];
    logic [LEVEL_W-1:0]  shadow_next [CHANNELS];
    logic                pending_reg, pending_next;
    logic [COUNT_W-1:0]  counter_reg, counter_next;
    logic                armed_reg, armed_next;
    logic [CHANNELS-1:0] gate_reg, gate_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic                led_reg, led_next;
    logic [CHANNELS-1:0] fire;

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    assign pop = op_valid && (!out_valid_reg || m_tready);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_count_reg  <= START_COUNT_RST;
            cutoff_count_reg <= CUTOFF_COUNT_RST;
            sync_timeout_reg <= SYNC_TIMEOUT_RST;
        end else if (cfg_wr.en) begin
            case (cfg_wr.addr)
                REG_START_COUNT:  start_count_reg  <= cfg_wr.data[COUNT_W-1:0];
                REG_CUTOFF_COUNT: cutoff_count_reg <= cfg_wr.data[COUNT_W-1:0];
                REG_SYNC_TIMEOUT: sync_timeout_reg <= cfg_wr.data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // per-channel firing compare
    always_comb begin
        for (int i = 0; i < CHANNELS; i++)
            fire[i] = (counter_reg < {1'b0, active_reg[i]});
    end

    // next state for the operation at the queue head
    always_comb begin
        active_next  = active_reg;
        shadow_next  = shadow_reg;
        pending_next = pending_reg;
        counter_next = counter_reg;
        armed_next   = armed_reg;
        gate_next    = gate_reg;
        ticks_next   = ticks_reg;
        led_next     = led_reg;
        case (op.kind)
            OP_TICK: begin
                if (ticks_reg >= sync_timeout_reg)
                    led_next = 1'b0;
                else
                    ticks_next = ticks_reg + 1'b1;
                if (armed_reg) begin
                    gate_next = gate_reg | fire;
                    if (counter_reg <= cutoff_count_reg) begin
                        gate_next  = '0;
                        armed_next = 1'b0;
                    end
                    counter_next = counter_reg - 1'b1;
                end
            end
            OP_ZERO_CROSS: begin
                gate_next = '0;
                if (pending_reg) begin
                    active_next  = shadow_reg;
                    pending_next = 1'b0;
                end
                counter_next = start_count_reg;
                armed_next   = 1'b1;
                led_next     = !led_reg;
                ticks_next   = '0;
            end
            OP_LEVEL: begin
                if (op.store)
                    shadow_next[op.chan[CH_IDX_W-1:0]] = op.level;
                if (op.last)
                    pending_next = 1'b1;
            end
            default: ;
        endcase
        out_data_next = '0;
        out_data_next[GATE_W-1:0] = GATE_W'(gate_next);
        out_data_next[GATE_W]     = led_next;
        out_data_next[GATE_W+1]   = (ticks_next >= sync_timeout_reg);
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                active_reg[i] <= '0;
                shadow_reg[i] <= '0;
            end
            pending_reg   <= 1'b0;
            counter_reg   <= '0;
            armed_reg     <= 1'b0;
            gate_reg      <= '0;
            ticks_reg     <= '0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                active_reg  <= active_next;
                shadow_reg  <= shadow_next;
                pending_reg <= pending_next;
                counter_reg <= counter_next;
                armed_reg   <= armed_next;
                gate_reg    <= gate_next;
                ticks_reg   <= ticks_next;
                led_reg     <= led_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/multichannel_phase_dimmer.sv =====
// top level of the sixteen-channel phase-angle dimmer
// depends on mpd_pkg, mpd_front, mpd_queue, mpd_back and the defines header
//
//   channel   ports                          word
//   input     s_tvalid/s_tready/s_t*         channel, level in tdata; mode in tuser; tlast
//   result    m_tvalid/m_tready/m_tdata      gate_bits, sync_led, sync_lost
//   config    cfg_wr_en/cfg_addr/cfg_wdata   start_count, cutoff_count, sync_timeout
//
// one word accepted per cycle unless stalled; each yields one registered result via the queue
// the front classifies into a two-entry queue; the back runs one op per cycle unless stalled
// the back stalls only on m_tready; the front stalls only on reset or a full queue
// synchronous active-low reset; no acceptance in the reset cycle or the one after
`include "multichannel_phase_dimmer_defines.svh"
module multichannel_phase_dimmer import mpd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] channel, [11:4] level, rest zero
    input  logic [MODE_W-1:0]     s_tuser,   // [1:0] mode
    input  logic                  s_tlast,   // frame_last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [15:0] gate_bits, [16] sync_led, [17] sync_lost
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      push;
    logic      pop;
    op_t       push_op;
    op_t       head_op;
    q_status_t q_status;
    cfg_wr_t   cfg_wr;

    assign cfg_wr.en   = cfg_wr_en;
    assign cfg_wr.addr = cfg_addr;
    assign cfg_wr.data = cfg_wdata;

    // accept and classify
    mpd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_op  (push_op)
    );

    // decoupling queue
    mpd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // execute and present results
    mpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .op       (head_op),
        .op_valid (!q_status.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // queue never holds more than its depth
    `MPD_ASSERT(a_queue_bound, (q_status.count <= QCNT_W'(QUEUE_DEPTH)), "queue overfilled")
    // an op is only taken from a non-empty queue
    `MPD_ASSERT(a_pop_nonempty, (pop |-> !q_status.empty), "pop from empty queue")
    // a queued op with a free result slot is executed at once
    `MPD_ASSERT(a_no_idle_back, ((!q_status.empty && (!m_tvalid || m_tready)) |-> pop), "back idled")

endmodule
